// ----- rtl/dlm_pkg.sv -----
// Shared types, codes and a helper function for the dense layer block.
package dlm_pkg;

  localparam int VAL_W  = 16;
  localparam int FRAC_W = 12;
  localparam int CNT_W  = 7;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS   = 2'd1;
  localparam logic [1:0] KIND_VECTOR = 2'd2;

  localparam logic CFG_IN_COUNT  = 1'b0;
  localparam logic CFG_OUT_COUNT = 1'b1;

  typedef struct packed {
    logic weight;
    logic bias;
    logic vector;
  } store_we_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  function automatic int addr_w(input int depth);
    addr_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- rtl/dense_layer_matvec.sv -----
// Fully connected layer top level: load decode, row/column walk, rounding and result register.
//
//   channel  | direction | handshake          | contents (low bits first)
//   in_      | slave     | tvalid/tready      | tdata: row, column, value; tuser: kind
//   out_     | master    | tvalid/tready      | tdata: out_index, result; tuser: clipped; tlast
//   cfg_     | write     | cfg_we             | cfg_addr selects in_count or out_count
//
// A load or a vector element that does not finish the vector is written, if in range, and the block stays idle.
// The element that finishes the vector starts the walk: each output row goes through the
// single multiply-accumulate, which reads one weight a cycle from the weight memory, and
// then through the pipeline drain and rounding.
// Input is held off during the walk; a stalled output holds the walk before the next row.
// Reset is synchronous; memories are not cleared and are valid only once written.
module dense_layer_matvec #(
  parameter int IN_MAX  = 64,
  parameter int OUT_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row[5:0], column[11:6], value[27:12], zero fill
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_index[5:0], result[21:6], zero fill
  output logic        out_tuser,  // clipped[0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata
);
  import dlm_pkg::*;

  localparam int WAW   = addr_w(OUT_MAX*IN_MAX);
  localparam int BAW   = addr_w(OUT_MAX);
  localparam int VAW   = addr_w(IN_MAX);
  localparam int ACC_W = 2*VAL_W + addr_w(IN_MAX) + 2;
  localparam int Q_W   = ACC_W - FRAC_W;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        in_count_r, out_count_r;
  logic [CNT_W-1:0]        ni, no;
  logic [CNT_W-1:0]        i_r, i_nxt, o_r, o_nxt;
  logic [WAW-1:0]          waddr_r, waddr_nxt, row_base_r, row_base_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]        out_index_r, out_index_nxt;
  logic signed [VAL_W-1:0] result_r, result_nxt;
  logic                    clip_r, clip_nxt, last_r, last_nxt;

  logic [ROW_W-1:0]        in_row;
  logic [COL_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_value;
  logic [1:0]              in_kind;
  logic                    in_xfer, vec_ok, vec_done;
  store_we_t               we;
  mac_ctl_t                mac_ctl;
  logic signed [VAL_W-1:0] w_rdata, b_rdata, v_rdata;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_done;
  logic signed [ACC_W-1:0] rounded;
  logic signed [Q_W-1:0]   q;
  logic                    emit_go;

  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_value = in_tdata[27:12];
  assign in_kind  = in_tuser;

  // Counts out of range are clamped to [1, MAX].
  always_comb begin
    if (in_count_r == '0) begin
      ni = CNT_W'(1);
    end else if (int'(in_count_r) > IN_MAX) begin
      ni = CNT_W'(IN_MAX);
    end else begin
      ni = in_count_r;
    end
    if (out_count_r == '0) begin
      no = CNT_W'(1);
    end else if (int'(out_count_r) > OUT_MAX) begin
      no = CNT_W'(OUT_MAX);
    end else begin
      no = out_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= CNT_W'(64);
      out_count_r <= CNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IN_COUNT:  in_count_r  <= cfg_wdata;
        CFG_OUT_COUNT: out_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign vec_ok    = (in_kind == KIND_VECTOR) && ({1'b0, in_col} < ni);
  assign vec_done  = in_xfer && vec_ok && ({1'b0, in_col} == ni - CNT_W'(1));

  always_comb begin
    we.weight = in_xfer && (in_kind == KIND_WEIGHT) &&
                (int'(in_row) < OUT_MAX) && (int'(in_col) < IN_MAX);
    we.bias   = in_xfer && (in_kind == KIND_BIAS) && (int'(in_row) < OUT_MAX);
    we.vector = in_xfer && vec_ok;
  end

  dlm_store #(
    .IN_MAX  (IN_MAX),
    .OUT_MAX (OUT_MAX)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .w_waddr (WAW'(in_row) * WAW'(IN_MAX) + WAW'(in_col)),
    .b_waddr (BAW'(in_row)),
    .v_waddr (VAW'(in_col)),
    .wdata   (in_value),
    .w_raddr (waddr_r),
    .b_raddr (BAW'(o_r)),
    .v_raddr (VAW'(i_r)),
    .w_rdata (w_rdata),
    .b_rdata (b_rdata),
    .v_rdata (v_rdata)
  );

  always_comb begin
    mac_ctl.valid = (state_r == ST_RUN);
    mac_ctl.first = (i_r == '0);
    mac_ctl.last  = (i_r == ni - CNT_W'(1));
  end

  dlm_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .weight (w_rdata),
    .vec    (v_rdata),
    .bias   (b_rdata),
    .acc    (acc),
    .done   (mac_done)
  );

  // Round half up, then floor by the arithmetic shift.
  assign rounded = acc + ACC_W'(1 << (FRAC_W - 1));
  assign q       = Q_W'(rounded >>> FRAC_W);
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    o_nxt         = o_r;
    waddr_nxt     = waddr_r;
    row_base_nxt  = row_base_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_index_nxt = out_index_r;
    result_nxt    = result_r;
    clip_nxt      = clip_r;
    last_nxt      = last_r;
    case (state_r)
      ST_IDLE: begin
        if (vec_done) begin
          state_nxt    = ST_RUN;
          i_nxt        = '0;
          o_nxt        = '0;
          waddr_nxt    = '0;
          row_base_nxt = '0;
        end
      end
      ST_RUN: begin
        if (i_r == ni - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          waddr_nxt = waddr_r + WAW'(1);
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = o_r[ROW_W-1:0];
          last_nxt      = (o_r == no - CNT_W'(1));
          if (q > Q_W'(32767)) begin
            result_nxt = 16'sh7fff;
            clip_nxt   = 1'b1;
          end else if (q < -Q_W'(32768)) begin
            result_nxt = -16'sh8000;
            clip_nxt   = 1'b1;
          end else begin
            result_nxt = q[VAL_W-1:0];
            clip_nxt   = 1'b0;
          end
          if (o_r == no - CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt    = ST_RUN;
            o_nxt        = o_r + CNT_W'(1);
            i_nxt        = '0;
            row_base_nxt = row_base_r + WAW'(IN_MAX);
            waddr_nxt    = row_base_r + WAW'(IN_MAX);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      o_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      o_r         <= o_nxt;
    end
    waddr_r     <= waddr_nxt;
    row_base_r  <= row_base_nxt;
    out_index_r <= out_index_nxt;
    result_r    <= result_nxt;
    clip_r      <= clip_nxt;
    last_r      <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, result_r, out_index_r};
  assign out_tuser  = clip_r;
  assign out_tlast  = last_r;

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_DRAIN)
    else $error("accumulator finished a row outside the drain state");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> i_r < ni)
    else $error("column walk ran past the vector length");

  a_waddr_track: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> waddr_r == row_base_r + WAW'(i_r))
    else $error("weight address out of step with row and column");

  a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !we.weight && !we.bias && !we.vector)
    else $error("memory written while a vector is being processed");

endmodule

// ----- rtl/dlm_store.sv -----
// Weight, bias and vector memories, each with one write and one registered read port.
module dlm_store #(
  parameter int IN_MAX  = 64,
  parameter int OUT_MAX = 64
) (
  input  logic                                            clk,
  input  dlm_pkg::store_we_t                              we,
  input  logic [dlm_pkg::addr_w(OUT_MAX*IN_MAX)-1:0]      w_waddr,
  input  logic [dlm_pkg::addr_w(OUT_MAX)-1:0]             b_waddr,
  input  logic [dlm_pkg::addr_w(IN_MAX)-1:0]              v_waddr,
  input  logic signed [dlm_pkg::VAL_W-1:0]                wdata,
  input  logic [dlm_pkg::addr_w(OUT_MAX*IN_MAX)-1:0]      w_raddr,
  input  logic [dlm_pkg::addr_w(OUT_MAX)-1:0]             b_raddr,
  input  logic [dlm_pkg::addr_w(IN_MAX)-1:0]              v_raddr,
  output logic signed [dlm_pkg::VAL_W-1:0]                w_rdata,
  output logic signed [dlm_pkg::VAL_W-1:0]                b_rdata,
  output logic signed [dlm_pkg::VAL_W-1:0]                v_rdata
);
  import dlm_pkg::*;

  logic signed [VAL_W-1:0] weight_mem [OUT_MAX*IN_MAX];
  logic signed [VAL_W-1:0] bias_mem   [OUT_MAX];
  logic signed [VAL_W-1:0] vector_mem [IN_MAX];

  always_ff @(posedge clk) begin
    if (we.weight) begin
      weight_mem[w_waddr] <= wdata;
    end
    w_rdata <= weight_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.bias) begin
      bias_mem[b_waddr] <= wdata;
    end
    b_rdata <= bias_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.vector) begin
      vector_mem[v_waddr] <= wdata;
    end
    v_rdata <= vector_mem[v_raddr];
  end

endmodule

// ----- rtl/dlm_mac.sv -----
// Multiply-accumulate pipeline: aligns control with memory data, multiplies, accumulates.
module dlm_mac #(
  parameter int ACC_W = 40
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dlm_pkg::mac_ctl_t                  ctl,
  input  logic signed [dlm_pkg::VAL_W-1:0]   weight,
  input  logic signed [dlm_pkg::VAL_W-1:0]   vec,
  input  logic signed [dlm_pkg::VAL_W-1:0]   bias,
  output logic signed [ACC_W-1:0]            acc,
  output logic                               done
);
  import dlm_pkg::*;

  mac_ctl_t                  ctl1_r, ctl2_r;
  logic signed [2*VAL_W-1:0] prod_r;
  logic signed [VAL_W-1:0]   bias2_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      done_r;

  // Control issued with the read addresses is registered in ctl1_r to line up with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.valid & ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= weight * vec;
    bias2_r <= bias;
    acc_r   <= acc_nxt;
  end

  // The first product of a row starts from the bias scaled to the product's fraction.
  always_comb begin
    acc_nxt = acc_r;
    if (ctl2_r.valid) begin
      if (ctl2_r.first) begin
        acc_nxt = (ACC_W'(bias2_r) <<< FRAC_W) + ACC_W'(prod_r);
      end else begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the dense layer matrix-vector block with a row result scoreboard.
module tb;
  import dlm_pkg::*;

  localparam int IN_MAX       = 64;
  localparam int OUT_MAX      = 64;
  localparam int ROW_CYCLES   = IN_MAX + 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASE_ITEMS  = 8;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [5:0]  index;
    logic [15:0] value;
    logic        clip;
    logic        last;
  } row_result_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_CHOKE} rx_mode_t;

  // Keeps its own copy of the stores and counts, and queues the rows each vector produces.
  class row_result_board;
    logic [15:0] weight_mem [OUT_MAX][IN_MAX];
    logic [15:0] bias_mem [OUT_MAX];
    logic [15:0] vec_mem [IN_MAX];
    bit          weight_set [OUT_MAX][IN_MAX];
    bit          bias_set [OUT_MAX];
    bit          vec_set [IN_MAX];
    logic [6:0]  in_count_reg  = 7'd64;
    logic [6:0]  out_count_reg = 7'd64;
    row_result_t pending_rows [$];
    int          errors;
    int          items_seen;
    int          vectors_done;
    int          rows_checked;
    int          clipped_rows;

    function int eff_count(logic [6:0] c, int max_val);
      if (c == 0) return 1;
      if (c > max_val) return max_val;
      return int'(c);
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction

    function void set_reg(logic addr, logic [6:0] data);
      if (addr == CFG_IN_COUNT) in_count_reg = data;
      else out_count_reg = data;
    endfunction

    function void compute_rows(int ni, int no);
      longint      acc;
      longint      rounded;
      row_result_t r;
      for (int o = 0; o < no; o++) begin
        acc = longint'($signed(bias_mem[o])) * 4096;
        for (int i = 0; i < ni; i++) begin
          acc += longint'($signed(weight_mem[o][i])) * longint'($signed(vec_mem[i]));
        end
        // Adding half an LSB before the arithmetic shift rounds ties upward.
        rounded = (acc + 2048) >>> 12;
        r.index = 6'(o);
        r.clip  = 1'b0;
        if (rounded > 32767) begin
          r.value = 16'h7FFF;
          r.clip  = 1'b1;
        end else if (rounded < -32768) begin
          r.value = 16'h8000;
          r.clip  = 1'b1;
        end else begin
          r.value = rounded[15:0];
        end
        r.last = (o == no - 1);
        pending_rows.push_back(r);
      end
      vectors_done++;
    endfunction

    function void note_item(logic [1:0] kind, logic [5:0] row, logic [5:0] col,
                            logic [15:0] value);
      int ni;
      ni = eff_count(in_count_reg, IN_MAX);
      items_seen++;
      case (kind)
        KIND_WEIGHT: begin
          weight_mem[row][col] = value;
          weight_set[row][col] = 1'b1;
        end
        KIND_BIAS: begin
          bias_mem[row] = value;
          bias_set[row] = 1'b1;
        end
        KIND_VECTOR: begin
          if (col < ni) begin
            vec_mem[col] = value;
            vec_set[col] = 1'b1;
            if (col == ni - 1) compute_rows(ni, eff_count(out_count_reg, OUT_MAX));
          end
        end
        default: ;
      endcase
    endfunction

    function void check_row(logic [5:0] idx, logic [15:0] value, logic clip, logic last);
      row_result_t e;
      rows_checked++;
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer: row %0d value %0d", $time, idx,
                 $signed(value));
        return;
      end
      e = pending_rows.pop_front();
      if (e.clip) clipped_rows++;
      if (idx !== e.index) begin
        errors++;
        $display("%0t: out_index mismatch: expected %0d, got %0d", $time, e.index, idx);
      end
      if (value !== e.value) begin
        errors++;
        $display("%0t: row %0d result mismatch: expected %0d, got %0d", $time, e.index,
                 $signed(e.value), $signed(value));
      end
      if (clip !== e.clip) begin
        errors++;
        $display("%0t: row %0d clipped mismatch: expected %0b, got %0b", $time, e.index,
                 e.clip, clip);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: row %0d last mismatch: expected %0b, got %0b", $time, e.index,
                 e.last, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // row[5:0], column[11:6], value[27:12], zero fill
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // out_index[5:0], result[21:6], zero fill
  logic        out_tuser;  // clipped[0]
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_addr;
  logic [6:0]  cfg_wdata;

  row_result_board board;
  int          items_sent;
  int          burst_left;
  int          settings_run;
  int          idle_cycles;
  rx_mode_t    rx_mode;
  int          rx_left;
  int          rx_phase;

  dense_layer_matvec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Every accepted transfer is seen here, on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        board.note_item(in_tuser, in_tdata[5:0], in_tdata[11:6], in_tdata[27:12]);
      end
      if (out_tvalid && out_tready) begin
        board.check_row(out_tdata[5:0], out_tdata[21:6], out_tuser, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d rows still due", $time, idle_cycles,
               board.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver switches between always ready, random stalls and long choke periods.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 300);
      rx_phase = 0;
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default:   out_tready <= ((rx_phase % 24) >= 18);
    endcase
  end

  function automatic logic [15:0] rand_q312();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 255));
      3:       return 16'(-$urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [1:0] kind, input logic [5:0] row,
                           input logic [5:0] col, input logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, value, col, row};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Loads every bias, weight and leading vector entry the next completed vector will read and that is still unwritten.
  task automatic make_ready();
    int ni;
    int no;
    ni = board.eff_count(board.in_count_reg, IN_MAX);
    no = board.eff_count(board.out_count_reg, OUT_MAX);
    for (int o = 0; o < no; o++) begin
      if (!board.bias_set[o]) send_item(KIND_BIAS, 6'(o), 6'($urandom), rand_q312());
    end
    for (int o = 0; o < no; o++) begin
      for (int i = 0; i < ni; i++) begin
        if (!board.weight_set[o][i]) send_item(KIND_WEIGHT, 6'(o), 6'(i), rand_q312());
      end
    end
    for (int i = 0; i < ni - 1; i++) begin
      if (!board.vec_set[i]) send_item(KIND_VECTOR, 6'($urandom), 6'(i), rand_q312());
    end
  endtask

  task automatic send_vector(input int ni);
    bit up;
    up = $urandom_range(0, 1);
    for (int c = 0; c < ni - 1; c++) begin
      send_item(KIND_VECTOR, 6'($urandom), up ? 6'(c) : 6'(ni - 2 - c), rand_q312());
    end
    make_ready();
    send_item(KIND_VECTOR, 6'($urandom), 6'(ni - 1), rand_q312());
  endtask

  // Writes both counts once the block is idle; called and returns at a falling edge.
  task automatic set_counts(input int in_val, input int out_val);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IN_COUNT;
    cfg_wdata <= in_val[6:0];
    @(posedge clk);
    board.set_reg(CFG_IN_COUNT, in_val[6:0]);
    @(negedge clk);
    cfg_addr  <= CFG_OUT_COUNT;
    cfg_wdata <= out_val[6:0];
    @(posedge clk);
    board.set_reg(CFG_OUT_COUNT, out_val[6:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic run_phase(input int n);
    int start;
    int ni;
    int pick;
    start = items_sent;
    ni = board.eff_count(board.in_count_reg, IN_MAX);
    while (items_sent - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_vector(ni);
      end else if (pick < 72) begin
        send_item(KIND_WEIGHT, 6'($urandom), 6'($urandom), rand_q312());
      end else if (pick < 84) begin
        send_item(KIND_BIAS, 6'($urandom), 6'($urandom), rand_q312());
      end else if (pick < 89) begin
        send_item(KIND_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom));
      end else if (pick < 94 && ni < IN_MAX) begin
        send_item(KIND_VECTOR, 6'($urandom), 6'($urandom_range(ni, IN_MAX - 1)), rand_q312());
      end else if (ni > 1) begin
        // A partial vector element that leaves the vector unfinished.
        send_item(KIND_VECTOR, 6'($urandom), 6'($urandom_range(0, ni - 2)), rand_q312());
      end else begin
        send_item(KIND_BIAS, 6'($urandom), 6'($urandom), rand_q312());
      end
    end
  endtask

  initial begin
    int phase_in [4];
    int phase_out [4];
    phase_in   = '{3, 2, 127, 1};
    phase_out  = '{5, 1, 1, 64};
    board      = new();
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_IN_COUNT;
    cfg_wdata  = '0;
    items_sent = 0;
    burst_left = 0;
    settings_run = 0;
    idle_cycles = 0;
    rx_left    = 0;
    rx_phase   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single row, single column: saturation both ways, ties and ignored items.
    set_counts(1, 1);
    send_item(KIND_WEIGHT, 6'd0, 6'd0, 16'h7FFF);
    send_item(KIND_BIAS, 6'd0, 6'd0, 16'h7FFF);
    send_item(KIND_VECTOR, 6'd0, 6'd0, 16'h7FFF);
    send_item(KIND_WEIGHT, 6'd0, 6'd0, 16'h8000);
    send_item(KIND_BIAS, 6'd0, 6'd0, 16'h8000);
    send_item(KIND_VECTOR, 6'd0, 6'd0, 16'h7FFF);
    send_item(KIND_VECTOR, 6'd0, 6'd0, 16'h8000);
    send_item(KIND_WEIGHT, 6'd0, 6'd0, 16'h0001);
    send_item(KIND_BIAS, 6'd0, 6'd0, 16'h0000);
    send_item(KIND_VECTOR, 6'd0, 6'd0, 16'h0800);
    send_item(KIND_VECTOR, 6'd0, 6'd0, 16'hF800);
    send_item(KIND_WEIGHT, 6'd0, 6'd0, 16'hFFFF);
    send_item(KIND_BIAS, 6'd0, 6'd0, 16'h7FFF);
    send_item(KIND_VECTOR, 6'd63, 6'd0, 16'h7FFF);
    send_item(KIND_UNUSED, 6'd63, 6'd63, 16'hFFFF);
    send_item(KIND_VECTOR, 6'd0, 6'd63, 16'h1234);
    send_item(KIND_WEIGHT, 6'd63, 6'd63, 16'h5A5A);
    send_item(KIND_BIAS, 6'd63, 6'd63, 16'hA5A5);

    // A zero in_count acts as one and an oversized out_count as the maximum.
    set_counts(0, 127);
    make_ready();
    send_item(KIND_VECTOR, 6'd0, 6'd0, 16'h8000);
    send_item(KIND_VECTOR, 6'd0, 6'd1, 16'h7FFF);

    // The third setting clamps an oversized in_count to the full vector length.
    for (int p = 0; p < 4; p++) begin
      set_counts(phase_in[p], phase_out[p]);
      run_phase(PHASE_ITEMS);
    end
    for (int p = 0; p < 2; p++) begin
      set_counts($urandom_range(1, 6), $urandom_range(1, 6));
      run_phase(PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2 * ROW_CYCLES) @(posedge clk);
    $display("Run covered %0d input transfers under %0d count settings, %0d vectors completed.",
             board.items_seen, settings_run, board.vectors_done);
    $display("Checked %0d result rows, %0d of them saturated.", board.rows_checked,
             board.clipped_rows);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
